@@ hw/rtl/phfba_pkg.sv @@
// ----------------------------------------------------------------------------
// phfba_pkg
// Shared types and constants for the per-host byte accounting block.
// ----------------------------------------------------------------------------
`default_nettype none

package phfba_pkg;

	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int BYTES_W = 32;
	localparam int LEN_W   = 16;
	localparam int ENTRY_W = MAC_W + IP_W + BYTES_W;
	localparam int CFG_W   = 32;
	localparam int CFG_AW  = 1;

	localparam logic [CFG_AW-1:0] REG_WARN_THRESHOLD = 1'b0;
	localparam logic [CFG_AW-1:0] REG_INTERVAL_TICKS = 1'b1;

	localparam logic [CFG_W-1:0] WARN_THRESHOLD_RST = 32'd2048;
	localparam logic [CFG_W-1:0] INTERVAL_TICKS_RST = 32'd10000;

	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic DIR_RX = 1'b0;
	localparam logic DIR_TX = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DRD,
		S_DOUT,
		S_ARD,
		S_ACMP
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_upd;
		logic out_load;
		logic out_last;
		logic dir;
	} ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/phfba_ram.sv @@
// ----------------------------------------------------------------------------
// phfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module phfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/phfba_unit.sv @@
// ----------------------------------------------------------------------------
// phfba_unit
// Shared compare/add unit: key match, saturating byte add, threshold flag.
// ----------------------------------------------------------------------------
`default_nettype none

module phfba_unit import phfba_pkg::*; (
	input  wire logic [MAC_W-1:0]   key_mac,
	input  wire logic [IP_W-1:0]    key_ip,
	input  wire logic [ENTRY_W-1:0] entry,
	input  wire logic [LEN_W-1:0]   frame_len,
	input  wire logic [CFG_W-1:0]   warn_threshold,
	output logic                    key_match,
	output logic [BYTES_W-1:0]      sum,
	output logic                    over
);

	logic [MAC_W-1:0]   ent_mac;
	logic [IP_W-1:0]    ent_ip;
	logic [BYTES_W-1:0] ent_bytes;
	logic [BYTES_W:0]   raw_sum;

	assign ent_mac   = entry[ENTRY_W-1 -: MAC_W];
	assign ent_ip    = entry[BYTES_W +: IP_W];
	assign ent_bytes = entry[BYTES_W-1:0];

	assign key_match = (ent_mac == key_mac) && (ent_ip == key_ip);
	assign raw_sum   = {1'b0, ent_bytes} + {{(BYTES_W + 1 - LEN_W){1'b0}}, frame_len};
	assign sum       = raw_sum[BYTES_W] ? {BYTES_W{1'b1}} : raw_sum[BYTES_W-1:0];
	assign over      = ent_bytes > warn_threshold;

endmodule

`default_nettype wire

@@ hw/rtl/phfba_seq.sv @@
// ----------------------------------------------------------------------------
// phfba_seq
// Sequencer: tick counting, table dump walk and per-table lookup/append.
// ----------------------------------------------------------------------------
`default_nettype none

module phfba_seq import phfba_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IW    = 4,
	parameter int CW    = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pkt_xfer,
	input  wire logic               pkt_cmd,
	input  wire logic [CFG_W-1:0]   interval_ticks,
	input  wire logic               key_match,
	input  wire logic               out_free,
	output logic                    busy,
	output logic [IW:0]             addr,
	output ctl_t                    ctl
);

	state_t         state_q, state_d;
	logic           tbl_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  rx_used_q, tx_used_q;
	logic [31:0]    elapsed_q;

	logic [CW-1:0]  cur_used;
	logic           scan_hit;
	logic           full;
	logic           dump_due;
	logic           is_last;

	assign cur_used = tbl_q ? tx_used_q : rx_used_q;
	assign scan_hit = idx_q < cur_used;
	assign full     = cur_used == CW'(DEPTH);
	assign dump_due = elapsed_q > interval_ticks;
	assign is_last  = ((idx_q + CW'(1)) == cur_used) && (tbl_q || (tx_used_q == '0));
	assign busy     = state_q != S_IDLE;
	assign addr     = {tbl_q, idx_q[IW-1:0]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pkt_xfer && pkt_cmd == CMD_PACKET) begin
					state_d = dump_due ? S_DRD : S_ARD;
				end
			end
			S_DRD: begin
				if (scan_hit) begin
					state_d = S_DOUT;
				end else if (tbl_q == DIR_TX) begin
					state_d = S_ARD;
				end
			end
			S_DOUT: begin
				if (out_free) begin
					state_d = S_DRD;
				end
			end
			S_ARD: begin
				if (scan_hit) begin
					state_d = S_ACMP;
				end else if (tbl_q == DIR_RX) begin
					state_d = S_IDLE;
				end
			end
			S_ACMP: begin
				if (key_match && tbl_q == DIR_RX) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_ARD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.dir      = tbl_q;
		ctl.out_last = is_last;
		case (state_q)
			S_DRD:  ctl.rd_en = scan_hit;
			S_DOUT: ctl.out_load = out_free;
			S_ARD: begin
				ctl.rd_en = scan_hit;
				ctl.wr_en = !scan_hit && !full;
			end
			S_ACMP: begin
				ctl.wr_en  = key_match;
				ctl.wr_upd = 1'b1;
			end
			default: ctl.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tbl_q     <= DIR_RX;
			idx_q     <= '0;
			rx_used_q <= '0;
			tx_used_q <= '0;
			elapsed_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (pkt_xfer) begin
						if (pkt_cmd == CMD_TICK) begin
							if (elapsed_q != '1) begin
								elapsed_q <= elapsed_q + 32'd1;
							end
						end else begin
							tbl_q <= dump_due ? DIR_RX : DIR_TX;
							idx_q <= '0;
						end
					end
				end
				S_DRD: begin
					if (!scan_hit) begin
						tbl_q <= DIR_TX;
						idx_q <= '0;
						if (tbl_q == DIR_TX) begin
							rx_used_q <= '0;
							tx_used_q <= '0;
							elapsed_q <= '0;
						end
					end
				end
				S_DOUT: begin
					if (out_free) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_ARD: begin
					if (!scan_hit) begin
						if (!full) begin
							if (tbl_q == DIR_TX) begin
								tx_used_q <= tx_used_q + CW'(1);
							end else begin
								rx_used_q <= rx_used_q + CW'(1);
							end
						end
						tbl_q <= DIR_RX;
						idx_q <= '0;
					end
				end
				S_ACMP: begin
					if (key_match) begin
						tbl_q <= DIR_RX;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: idx_q <= '0;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/per_host_flow_byte_accounting.sv @@
// ----------------------------------------------------------------------------
// per_host_flow_byte_accounting
// Per-host receive/send byte counters keyed by (MAC, IPv4), with periodic
// report dump and table clear driven by a tick count.
//
//   channel  dir  handshake             payload
//   pkt      in   pkt_valid/pkt_stall   command, src/dst mac+ip, frame_len
//   rpt      out  rpt_valid/rpt_stall   direction, host_mac/ip, byte_total,
//                                       over_threshold, last
//   cfg      in   cfg_we                cfg_addr, cfg_wdata
//
// A tick only advances the tick count. A packet's lookup/append reads and
// compares the used entries of a table in turn on the single table RAM
// read port; a key hit ends that table's scan early. A due dump first sends
// one report per used entry, held by rpt_stall; then the lookup sees empty
// tables. pkt_stall is high while a packet is in progress. Reset empties
// both tables and clears the tick count; table contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module per_host_flow_byte_accounting import phfba_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               pkt_valid,
	output logic                    pkt_stall,
	input  wire logic               command,
	input  wire logic [MAC_W-1:0]   src_mac,
	input  wire logic [IP_W-1:0]    src_ip,
	input  wire logic [MAC_W-1:0]   dst_mac,
	input  wire logic [IP_W-1:0]    dst_ip,
	input  wire logic [LEN_W-1:0]   frame_len,

	output logic                    rpt_valid,
	input  wire logic               rpt_stall,
	output logic                    direction,
	output logic [MAC_W-1:0]        host_mac,
	output logic [IP_W-1:0]         host_ip,
	output logic [BYTES_W-1:0]      byte_total,
	output logic                    over_threshold,
	output logic                    last,

	input  wire logic               cfg_we,
	input  wire logic [CFG_AW-1:0]  cfg_addr,
	input  wire logic [CFG_W-1:0]   cfg_wdata
);

	localparam int IW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW        = $clog2(TABLE_DEPTH + 1);
	localparam int RAM_DEPTH = 2 ** (IW + 1);

	logic [CFG_W-1:0]   warn_threshold_q;
	logic [CFG_W-1:0]   interval_ticks_q;

	logic [MAC_W-1:0]   src_mac_q, dst_mac_q;
	logic [IP_W-1:0]    src_ip_q, dst_ip_q;
	logic [LEN_W-1:0]   frame_len_q;

	logic               pkt_xfer;
	logic               busy;
	logic               out_free;
	logic [IW:0]        addr;
	ctl_t               ctl;

	logic [MAC_W-1:0]   key_mac;
	logic [IP_W-1:0]    key_ip;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;
	logic               key_match;
	logic [BYTES_W-1:0] sum;
	logic               over;

	assign pkt_stall = busy;
	assign pkt_xfer  = pkt_valid && !pkt_stall;
	assign out_free  = !rpt_valid || !rpt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_threshold_q <= WARN_THRESHOLD_RST;
			interval_ticks_q <= INTERVAL_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WARN_THRESHOLD: warn_threshold_q <= cfg_wdata;
				REG_INTERVAL_TICKS: interval_ticks_q <= cfg_wdata;
				default: warn_threshold_q <= warn_threshold_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_xfer) begin
			src_mac_q   <= src_mac;
			src_ip_q    <= src_ip;
			dst_mac_q   <= dst_mac;
			dst_ip_q    <= dst_ip;
			frame_len_q <= frame_len;
		end
	end

	assign key_mac = (ctl.dir == DIR_TX) ? src_mac_q : dst_mac_q;
	assign key_ip  = (ctl.dir == DIR_TX) ? src_ip_q  : dst_ip_q;
	assign wr_data = {key_mac, key_ip,
		ctl.wr_upd ? sum : {{(BYTES_W - LEN_W){1'b0}}, frame_len_q}};

	phfba_seq #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW),
		.CW    (CW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.pkt_xfer       (pkt_xfer),
		.pkt_cmd        (command),
		.interval_ticks (interval_ticks_q),
		.key_match      (key_match),
		.out_free       (out_free),
		.busy           (busy),
		.addr           (addr),
		.ctl            (ctl)
	);

	phfba_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	phfba_unit u_unit (
		.key_mac        (key_mac),
		.key_ip         (key_ip),
		.entry          (rd_data),
		.frame_len      (frame_len_q),
		.warn_threshold (warn_threshold_q),
		.key_match      (key_match),
		.sum            (sum),
		.over           (over)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid <= 1'b0;
		end else if (ctl.out_load) begin
			rpt_valid <= 1'b1;
		end else if (!rpt_stall) begin
			rpt_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			direction      <= ctl.dir;
			host_mac       <= rd_data[ENTRY_W-1 -: MAC_W];
			host_ip        <= rd_data[BYTES_W +: IP_W];
			byte_total     <= rd_data[BYTES_W-1:0];
			over_threshold <= over;
			last           <= ctl.out_last;
		end
	end

endmodule

`default_nettype wire
